@@ rtl/core/c_string_literal_unescaper_macros.svh @@
// Assertion macros for the C string literal unescaper checker.
// Used by the checker file only; needs nothing else.
`ifndef C_STRING_LITERAL_UNESCAPER_MACROS_SVH
`define C_STRING_LITERAL_UNESCAPER_MACROS_SVH

// Same-cycle implication, held off during reset.
`define CSLU_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cslu check failed");

// Next-cycle implication, held off during reset.
`define CSLU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cslu check failed");

`endif

@@ rtl/core/cslu_pkg.sv @@
// Shared types and constants of the C string literal unescaper.
// No dependencies; imported by cslu_fsm, the top level, the checker and the bench.
`timescale 1ns / 1ps

package cslu_pkg;

	// Parse phase codes
	localparam int PH_W = 3;
	localparam logic [PH_W-1:0] PH_FIRST  = 3'd0;
	localparam logic [PH_W-1:0] PH_BODY   = 3'd1;
	localparam logic [PH_W-1:0] PH_ESCAPE = 3'd2;
	localparam logic [PH_W-1:0] PH_HEX1   = 3'd3;
	localparam logic [PH_W-1:0] PH_HEX2   = 3'd4;
	localparam logic [PH_W-1:0] PH_DONE   = 3'd5;
	localparam logic [PH_W-1:0] PH_FAILED = 3'd6;

	// Status codes
	localparam logic [1:0] ST_BUSY = 2'd0;
	localparam logic [1:0] ST_OK   = 2'd1;
	localparam logic [1:0] ST_FAIL = 2'd2;

	// Error codes
	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_NO_QUOTE = 3'd1;
	localparam logic [2:0] ERR_EARLY    = 3'd2;
	localparam logic [2:0] ERR_NEWLINE  = 3'd3;
	localparam logic [2:0] ERR_BAD_HEX  = 3'd4;
	localparam logic [2:0] ERR_BAD_ESC  = 3'd5;

	// Characters
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_APOS   = 8'h27;
	localparam logic [7:0] CH_QMARK  = 8'h3F;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_X      = 8'h78;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_LA     = 8'h61;
	localparam logic [7:0] CH_LB     = 8'h62;
	localparam logic [7:0] CH_LF_    = 8'h66;
	localparam logic [7:0] CH_LN     = 8'h6E;
	localparam logic [7:0] CH_LR     = 8'h72;
	localparam logic [7:0] CH_LT     = 8'h74;
	localparam logic [7:0] CH_LV     = 8'h76;
	localparam logic [7:0] CH_UA     = 8'h41;
	localparam logic [7:0] CH_UF     = 8'h46;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_string;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_valid;
		logic [1:0] status;
		logic [2:0] error_kind;
	} result_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] value;
	} hex_t;

	typedef struct packed {
		logic       hit;
		logic [7:0] value;
	} esc_t;

	// Decode one hex digit
	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t h;
		h = '0;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			h.ok = 1'b1;
			h.value = 4'(c - CH_ZERO);
		end else if (c >= CH_LA && c <= CH_LF_) begin
			h.ok = 1'b1;
			h.value = 4'(c - CH_LA + 8'd10);
		end else if (c >= CH_UA && c <= CH_UF) begin
			h.ok = 1'b1;
			h.value = 4'(c - CH_UA + 8'd10);
		end
		return h;
	endfunction

	// Map a simple escape letter to its byte
	function automatic esc_t esc_decode(input logic [7:0] c);
		esc_t e;
		e.hit = 1'b1;
		unique case (c)
			CH_APOS, CH_DQUOTE, CH_QMARK, CH_BSLASH: e.value = c;
			CH_LA:   e.value = 8'h07;
			CH_LB:   e.value = 8'h08;
			CH_LF_:  e.value = 8'h0C;
			CH_LN:   e.value = 8'h0A;
			CH_LR:   e.value = 8'h0D;
			CH_LT:   e.value = 8'h09;
			CH_LV:   e.value = 8'h0B;
			CH_ZERO: e.value = 8'h00;
			default: begin
				e.hit = 1'b0;
				e.value = 8'h00;
			end
		endcase
		return e;
	endfunction

endpackage

@@ rtl/core/cslu_if.sv @@
// Valid/ready channel interfaces of the C string literal unescaper.
// Depends on cslu_pkg for nothing but stands after it in compile order.
`timescale 1ns / 1ps

interface cslu_item_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_string;
	modport source (output valid, output data_byte, output end_of_string, input ready);
	modport sink (input valid, input data_byte, input end_of_string, output ready);
endinterface

interface cslu_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_valid;
	logic [1:0] status;
	logic [2:0] error_kind;
	modport source (output valid, output out_byte, output out_valid, output status,
		output error_kind, input ready);
	modport sink (input valid, input out_byte, input out_valid, input status,
		input error_kind, output ready);
endinterface

interface cslu_cfg_if;
	logic valid;
	logic ready;
	logic quoted_mode;
	modport source (output valid, output quoted_mode, input ready);
	modport sink (input valid, input quoted_mode, output ready);
endinterface

@@ rtl/core/cslu_fsm.sv @@
// Parse state and per-item decode of the unescaper.
// Depends on cslu_pkg.
`timescale 1ns / 1ps

module cslu_fsm import cslu_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    advance,
	input  logic    quoted_mode,
	input  item_t   item,
	output result_t result
);

	logic [PH_W-1:0] phase_q, phase_d;
	logic [3:0]      nibble_q, nibble_d;
	logic            hex_ok_q, hex_ok_d;
	logic [2:0]      held_err_q, held_err_d;

	logic       as_body;
	logic       fail_now;
	logic [2:0] fail_code;
	logic [7:0] c;
	logic       eos;
	hex_t       hx;
	esc_t       es;

	assign c   = item.data_byte;
	assign eos = item.end_of_string;
	assign hx  = hex_decode(c);
	assign es  = esc_decode(c);

	// Decode one item against the current phase
	always_comb begin
		result     = '0;
		result.status     = ST_BUSY;
		result.error_kind = ERR_NONE;
		phase_d    = phase_q;
		nibble_d   = nibble_q;
		hex_ok_d   = hex_ok_q;
		held_err_d = held_err_q;
		as_body    = 1'b0;
		fail_now   = 1'b0;
		fail_code  = ERR_NONE;

		unique case (phase_q)
			PH_FIRST: begin
				if (quoted_mode) begin
					if (eos) begin
						result.status     = ST_FAIL;
						result.error_kind = ERR_NO_QUOTE;
					end else if (c != CH_DQUOTE) begin
						fail_now  = 1'b1;
						fail_code = ERR_NO_QUOTE;
					end else begin
						phase_d = PH_BODY;
					end
				end else begin
					as_body = 1'b1;
				end
			end
			PH_BODY: as_body = 1'b1;
			PH_ESCAPE: begin
				if (eos) begin
					phase_d           = PH_FIRST;
					result.status     = ST_FAIL;
					result.error_kind = ERR_EARLY;
				end else if (c == CH_X) begin
					phase_d = PH_HEX1;
				end else if (c == CH_CR || c == CH_LF) begin
					fail_now  = 1'b1;
					fail_code = ERR_NEWLINE;
				end else if (es.hit) begin
					phase_d          = PH_BODY;
					result.out_byte  = es.value;
					result.out_valid = 1'b1;
				end else begin
					fail_now  = 1'b1;
					fail_code = ERR_BAD_ESC;
				end
			end
			PH_HEX1: begin
				if (eos) begin
					phase_d           = PH_FIRST;
					result.status     = ST_FAIL;
					result.error_kind = ERR_BAD_HEX;
				end else begin
					hex_ok_d = hx.ok;
					nibble_d = hx.ok ? hx.value : 4'd0;
					phase_d  = PH_HEX2;
				end
			end
			PH_HEX2: begin
				if (eos) begin
					phase_d           = PH_FIRST;
					result.status     = ST_FAIL;
					result.error_kind = ERR_BAD_HEX;
				end else if (!hx.ok || !hex_ok_q) begin
					fail_now  = 1'b1;
					fail_code = ERR_BAD_HEX;
				end else begin
					phase_d          = PH_BODY;
					result.out_byte  = {nibble_q, hx.value};
					result.out_valid = 1'b1;
				end
			end
			PH_DONE: begin
				if (eos) phase_d = PH_FIRST;
				result.status = ST_OK;
			end
			PH_FAILED: begin
				if (eos) phase_d = PH_FIRST;
				result.status     = ST_FAIL;
				result.error_kind = held_err_q;
			end
			default: phase_d = PH_FIRST;
		endcase

		// Body byte, shared by an unquoted first byte
		if (as_body) begin
			if (eos) begin
				phase_d = PH_FIRST;
				if (quoted_mode) begin
					result.status     = ST_FAIL;
					result.error_kind = ERR_EARLY;
				end else begin
					result.status = ST_OK;
				end
			end else if (c == CH_CR || c == CH_LF) begin
				fail_now  = 1'b1;
				fail_code = ERR_NEWLINE;
			end else if (quoted_mode && c == CH_DQUOTE) begin
				phase_d       = PH_DONE;
				result.status = ST_OK;
			end else if (c == CH_BSLASH) begin
				phase_d = PH_ESCAPE;
			end else begin
				result.out_byte  = c;
				result.out_valid = 1'b1;
			end
		end

		// Latch a failure and hold its code
		if (fail_now) begin
			phase_d           = PH_FAILED;
			held_err_d        = fail_code;
			result.status     = ST_FAIL;
			result.error_kind = fail_code;
		end
	end

	// Advance the state on each processed item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_FIRST;
			nibble_q   <= '0;
			hex_ok_q   <= 1'b0;
			held_err_q <= ERR_NONE;
		end else if (advance) begin
			phase_q    <= phase_d;
			nibble_q   <= nibble_d;
			hex_ok_q   <= hex_ok_d;
			held_err_q <= held_err_d;
		end
	end

endmodule

@@ rtl/core/c_string_literal_unescaper.sv @@
// C string literal unescaper: one result per input byte or end item.
// Path: each item is held in the input register, decoded by cslu_fsm, then held in the result register.
// Throughput: one item per cycle, set by the parse state update, while the result slot is free or being taken.
// Reset: arst_n clears both stage valids, the parse state and quoted_mode.
// Depends on cslu_pkg, the channel interfaces and cslu_fsm.
`timescale 1ns / 1ps

module c_string_literal_unescaper import cslu_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	cslu_cfg_if.sink      cfg,
	cslu_item_if.sink     raw,
	cslu_result_if.source dec
);

	logic    quoted_mode_q;
	logic    valid_s1;
	item_t   item_s1;
	logic    valid_s2;
	result_t result_s2;
	result_t result_next;
	logic    advance;

	// Configuration register, always writable
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quoted_mode_q <= 1'b0;
		end else if (cfg.valid) begin
			quoted_mode_q <= cfg.quoted_mode;
		end
	end

	// Move the input stage forward when the result slot is free or being taken
	assign advance   = valid_s1 && (!valid_s2 || dec.ready);
	assign raw.ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (raw.ready) begin
			valid_s1 <= raw.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (raw.valid && raw.ready) begin
			item_s1.data_byte     <= raw.data_byte;
			item_s1.end_of_string <= raw.end_of_string;
		end
	end

	cslu_fsm u_fsm (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.quoted_mode (quoted_mode_q),
		.item        (item_s1),
		.result      (result_next)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (dec.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) result_s2 <= result_next;
	end

	assign dec.valid      = valid_s2;
	assign dec.out_byte   = result_s2.out_byte;
	assign dec.out_valid  = result_s2.out_valid;
	assign dec.status     = result_s2.status;
	assign dec.error_kind = result_s2.error_kind;

endmodule

@@ rtl/core/cslu_checker.sv @@
// Port-level checks for the C string literal unescaper, bound to the top level.
// Depends on cslu_pkg and c_string_literal_unescaper_macros.svh.
`timescale 1ns / 1ps
`include "c_string_literal_unescaper_macros.svh"

module cslu_checker import cslu_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       dec_valid,
	input logic       dec_ready,
	input logic [7:0] out_byte,
	input logic       out_valid,
	input logic [1:0] status,
	input logic [2:0] error_kind
);

	logic [13:0] res_bits;
	logic        is_fail;
	logic        has_err;

	// Gather the result payload and its failure flags
	assign res_bits = {out_byte, out_valid, status, error_kind};
	assign is_fail  = (status == ST_FAIL);
	assign has_err  = (error_kind != ERR_NONE);

	// A stalled result holds until the transfer
	`CSLU_ASSERT_NEXT(a_stall_hold, clk, arst_n, dec_valid && !dec_ready, dec_valid && $stable(res_bits))

	// A decoded byte only comes while the string is in progress
	`CSLU_ASSERT_IMPLY(a_byte_busy, clk, arst_n, dec_valid && out_valid, status == ST_BUSY && !has_err)

	// No byte value without out_valid
	`CSLU_ASSERT_IMPLY(a_byte_zero, clk, arst_n, dec_valid && !out_valid, out_byte == 8'h00)

	// An error code goes with a failure and only with one
	`CSLU_ASSERT_IMPLY(a_err_match, clk, arst_n, dec_valid, is_fail == has_err && status <= ST_FAIL)

endmodule

bind c_string_literal_unescaper cslu_checker u_cslu_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.dec_valid  (dec.valid),
	.dec_ready  (dec.ready),
	.out_byte   (dec.out_byte),
	.out_valid  (dec.out_valid),
	.status     (dec.status),
	.error_kind (dec.error_kind)
);

@@ tb/tb_top.sv @@
// Self-checking bench for c_string_literal_unescaper: directed strings, then random strings.
// A scoreboard class predicts one decoded result per transfer in.
// Needs cslu_pkg and the channel interfaces from cslu_if.sv.
`timescale 1ns / 1ps

module tb_top;
	import cslu_pkg::*;

	localparam int STALL_LIMIT  = 2000;
	localparam int RANDOM_ITEMS = 600;
	localparam logic [7:0] SIMPLE_ESC [12] = '{CH_APOS, CH_DQUOTE, CH_QMARK, CH_BSLASH,
		CH_LA, CH_LB, CH_LF_, CH_LN, CH_LR, CH_LT, CH_LV, CH_ZERO};

	// Tracks the parser state and queues one expected result per transfer in
	class unescape_scoreboard;
		logic       quoted;
		logic [2:0] phase;
		logic [3:0] hi_nibble;
		logic       hi_ok;
		logic [2:0] held_err;
		result_t    expected_decodes[$];
		int         mismatches;

		function new();
			quoted = 1'b0;
			phase = PH_FIRST;
			hi_nibble = 4'h0;
			hi_ok = 1'b0;
			held_err = ERR_NONE;
			mismatches = 0;
		endfunction

		function void set_quoted(logic m);
			quoted = m;
		endfunction

		function int hex_nibble(logic [7:0] c);
			if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
			if (c >= CH_LA && c <= CH_LF_) return int'(c - CH_LA) + 10;
			if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
			return -1;
		endfunction

		function result_t fail_with(logic [2:0] err);
			result_t r;
			phase = PH_FAILED;
			held_err = err;
			r.out_byte = 8'h00;
			r.out_valid = 1'b0;
			r.status = ST_FAIL;
			r.error_kind = err;
			return r;
		endfunction

		// Plain string body: pass bytes, catch quote, backslash, newline and end
		function result_t body_item(logic [7:0] c, logic fin);
			result_t r;
			r.out_byte = 8'h00;
			r.out_valid = 1'b0;
			r.status = ST_BUSY;
			r.error_kind = ERR_NONE;
			if (fin) begin
				phase = PH_FIRST;
				if (quoted) begin
					r.status = ST_FAIL;
					r.error_kind = ERR_EARLY;
				end else begin
					r.status = ST_OK;
				end
			end else if (c == CH_CR || c == CH_LF) begin
				r = fail_with(ERR_NEWLINE);
			end else if (quoted && c == CH_DQUOTE) begin
				phase = PH_DONE;
				r.status = ST_OK;
			end else if (c == CH_BSLASH) begin
				phase = PH_ESCAPE;
			end else begin
				r.out_byte = c;
				r.out_valid = 1'b1;
			end
			return r;
		endfunction

		function result_t decode_step(logic [7:0] c, logic fin);
			result_t r;
			int h;
			r.out_byte = 8'h00;
			r.out_valid = 1'b0;
			r.status = ST_BUSY;
			r.error_kind = ERR_NONE;
			case (phase)
				PH_FIRST: begin
					if (!quoted) begin
						r = body_item(c, fin);
					end else if (fin) begin
						// end as first item keeps the parser waiting for a string
						r.status = ST_FAIL;
						r.error_kind = ERR_NO_QUOTE;
					end else if (c != CH_DQUOTE) begin
						r = fail_with(ERR_NO_QUOTE);
					end else begin
						phase = PH_BODY;
					end
				end
				PH_BODY: r = body_item(c, fin);
				PH_ESCAPE: begin
					if (fin) begin
						phase = PH_FIRST;
						r.status = ST_FAIL;
						r.error_kind = ERR_EARLY;
					end else if (c == CH_X) begin
						phase = PH_HEX1;
					end else if (c == CH_CR || c == CH_LF) begin
						r = fail_with(ERR_NEWLINE);
					end else begin
						r.out_valid = 1'b1;
						phase = PH_BODY;
						case (c)
							CH_APOS, CH_DQUOTE, CH_QMARK, CH_BSLASH: r.out_byte = c;
							CH_LA: r.out_byte = 8'h07;
							CH_LB: r.out_byte = 8'h08;
							CH_LF_: r.out_byte = 8'h0C;
							CH_LN: r.out_byte = 8'h0A;
							CH_LR: r.out_byte = 8'h0D;
							CH_LT: r.out_byte = 8'h09;
							CH_LV: r.out_byte = 8'h0B;
							CH_ZERO: r.out_byte = 8'h00;
							default: r = fail_with(ERR_BAD_ESC);
						endcase
					end
				end
				PH_HEX1: begin
					if (fin) begin
						phase = PH_FIRST;
						r.status = ST_FAIL;
						r.error_kind = ERR_BAD_HEX;
					end else begin
						// hold the first digit; judge only once the second arrives
						h = hex_nibble(c);
						hi_ok = (h >= 0);
						hi_nibble = (h >= 0) ? 4'(h) : 4'h0;
						phase = PH_HEX2;
					end
				end
				PH_HEX2: begin
					h = fin ? -1 : hex_nibble(c);
					if (fin) begin
						phase = PH_FIRST;
						r.status = ST_FAIL;
						r.error_kind = ERR_BAD_HEX;
					end else if (h < 0 || !hi_ok) begin
						r = fail_with(ERR_BAD_HEX);
					end else begin
						phase = PH_BODY;
						r.out_byte = {hi_nibble, 4'(h)};
						r.out_valid = 1'b1;
					end
				end
				PH_DONE: begin
					if (fin) phase = PH_FIRST;
					r.status = ST_OK;
				end
				PH_FAILED: begin
					r.status = ST_FAIL;
					r.error_kind = held_err;
					if (fin) phase = PH_FIRST;
				end
				default: phase = PH_FIRST;
			endcase
			return r;
		endfunction

		function void note_item(logic [7:0] c, logic fin);
			result_t want;
			want = decode_step(c, fin);
			expected_decodes.insert(expected_decodes.size(), want);
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (expected_decodes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: byte %02h valid %0d status %0d err %0d",
						got.out_byte, got.out_valid, got.status, got.error_kind);
				return;
			end
			want = expected_decodes.pop_front();
			if (got.out_byte !== want.out_byte || got.out_valid !== want.out_valid ||
				got.status !== want.status || got.error_kind !== want.error_kind) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: want byte %02h valid %0d status %0d err %0d, %s",
						want.out_byte, want.out_valid, want.status, want.error_kind,
						$sformatf("got byte %02h valid %0d status %0d err %0d",
						got.out_byte, got.out_valid, got.status, got.error_kind));
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic raw_up;
	logic src_calm;
	logic snk_calm;
	int   items_sent;
	int   idle_cycles;

	unescape_scoreboard board = new();

	cslu_cfg_if    cfg_ch();
	cslu_item_if   raw_ch();
	cslu_result_if dec_ch();

	c_string_literal_unescaper uut (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_ch),
		.raw   (raw_ch),
		.dec   (dec_ch)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// End the run when no transfer of any kind happens for too long
	always @(posedge clk) begin
		if ((raw_ch.valid && raw_ch.ready) || (dec_ch.valid && dec_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready) || !arst_n) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Accept results with random stalls and check each one
	initial begin : result_sink
		int stall;
		result_t got;
		dec_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = snk_calm ? 0 : $urandom_range(0, 19);
			if (stall > 0) begin
				dec_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			dec_ch.ready <= 1'b1;
			@(posedge clk);
			while (!dec_ch.valid) @(posedge clk);
			got.out_byte = dec_ch.out_byte;
			got.out_valid = dec_ch.out_valid;
			got.status = dec_ch.status;
			got.error_kind = dec_ch.error_kind;
			board.check_result(got);
		end
	end

	// Offer one item after a random gap; keep valid up for a back-to-back transfer
	task automatic send_item(input logic [7:0] c, input logic fin);
		int gap;
		gap = src_calm ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			if (raw_up) raw_ch.valid <= 1'b0;
			raw_up = 1'b0;
			repeat (gap) @(posedge clk);
		end
		raw_ch.valid <= 1'b1;
		raw_ch.data_byte <= c;
		raw_ch.end_of_string <= fin;
		raw_up = 1'b1;
		@(posedge clk);
		while (!raw_ch.ready) @(posedge clk);
		board.note_item(c, fin);
		items_sent++;
	endtask

	task automatic drop_input();
		if (raw_up) raw_ch.valid <= 1'b0;
		raw_up = 1'b0;
	endtask

	// Write the mode register once the block has drained
	task automatic load_quoted_mode(input logic m);
		drop_input();
		while (board.expected_decodes.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.quoted_mode <= m;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		board.set_quoted(m);
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic logic [7:0] rand_hex_digit();
		int v;
		v = $urandom_range(0, 21);
		if (v < 10) return CH_ZERO + 8'(v);
		if (v < 16) return CH_LA + 8'(v - 10);
		return CH_UA + 8'(v - 16);
	endfunction

	// One piece of string body: clean bytes and escapes, or broken ones when noisy
	task automatic send_token(input bit noisy);
		logic [7:0] c;
		c = 8'($urandom);
		if (!noisy) begin
			case ($urandom_range(0, 4))
				0, 1, 2: begin
					if (c == CH_BSLASH || c == CH_DQUOTE || c == CH_CR || c == CH_LF)
						c = c ^ 8'h80;
					send_item(c, 1'b0);
				end
				3: begin
					send_item(CH_BSLASH, 1'b0);
					send_item(SIMPLE_ESC[$urandom_range(0, 11)], 1'b0);
				end
				default: begin
					send_item(CH_BSLASH, 1'b0);
					send_item(CH_X, 1'b0);
					send_item(rand_hex_digit(), 1'b0);
					send_item(rand_hex_digit(), 1'b0);
				end
			endcase
		end else begin
			case ($urandom_range(0, 5))
				0: send_item(c, 1'b0);
				1: begin
					send_item(CH_BSLASH, 1'b0);
					send_item(c, 1'b0);
				end
				2: begin
					send_item(CH_BSLASH, 1'b0);
					send_item(CH_X, 1'b0);
					send_item(c, 1'b0);
					send_item(8'($urandom), 1'b0);
				end
				3: begin
					send_item(CH_BSLASH, 1'b0);
					send_item(CH_X, 1'b0);
					send_item(rand_hex_digit(), 1'b0);
					send_item(c, 1'b0);
				end
				4: begin
					if ($urandom_range(0, 1)) send_item(CH_BSLASH, 1'b0);
					send_item($urandom_range(0, 1) ? CH_CR : CH_LF, 1'b0);
				end
				default: begin
					// leave an escape open so the string can end inside it
					send_item(CH_BSLASH, 1'b0);
					if ($urandom_range(0, 1)) send_item(CH_X, 1'b0);
				end
			endcase
		end
	endtask

	// One whole string closed by an end item
	task automatic send_string(input logic quoted, input bit tidy);
		int n;
		n = $urandom_range(0, 6);
		if (quoted && (tidy || $urandom_range(0, 3) != 0)) send_item(CH_DQUOTE, 1'b0);
		repeat (n) send_token(!tidy && $urandom_range(0, 2) == 0);
		if (quoted && (tidy || $urandom_range(0, 1) != 0)) send_item(CH_DQUOTE, 1'b0);
		if ($urandom_range(0, 5) == 0) send_item(8'($urandom), 1'b0);
		send_item(8'($urandom), 1'b1);
	endtask

	initial begin : stimulus
		int phase_idx;
		int phase_end;
		int random_start;
		arst_n = 1'b0;
		raw_up = 1'b0;
		src_calm = 1'b0;
		snk_calm = 1'b0;
		items_sent = 0;
		idle_cycles = 0;
		raw_ch.valid = 1'b0;
		raw_ch.data_byte = 8'h00;
		raw_ch.end_of_string = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.quoted_mode = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Unquoted: byte extremes pass through, end finishes ok
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'h5A, 1'b1);
		load_quoted_mode(1'b1);
		// Quoted: hex escape in both cases, closing quote, ignored tail, rearm
		send_item(CH_DQUOTE, 1'b0);
		send_item(CH_BSLASH, 1'b0);
		send_item(CH_X, 1'b0);
		send_item(CH_UF, 1'b0);
		send_item(CH_LA, 1'b0);
		send_item(CH_DQUOTE, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'h00, 1'b1);
		// End as the very first item, then a missing opening quote
		send_item(8'hFF, 1'b1);
		send_item(CH_LA, 1'b0);
		send_item(8'h00, 1'b1);
		// Bad escape letter
		send_item(CH_DQUOTE, 1'b0);
		send_item(CH_BSLASH, 1'b0);
		send_item(8'h71, 1'b0);
		send_item(8'h00, 1'b1);
		// Raw newline in the body
		send_item(CH_DQUOTE, 1'b0);
		send_item(CH_LF, 1'b0);
		send_item(8'h00, 1'b1);
		// End right after a backslash
		send_item(CH_DQUOTE, 1'b0);
		send_item(CH_BSLASH, 1'b0);
		send_item(8'h00, 1'b1);

		// Random phases, each with its own mode and idling pattern
		random_start = items_sent;
		phase_idx = 0;
		while (items_sent < random_start + RANDOM_ITEMS) begin
			load_quoted_mode(phase_idx < 2 ? phase_idx[0] : 1'($urandom_range(0, 1)));
			src_calm = ($urandom_range(0, 3) == 0);
			snk_calm = ($urandom_range(0, 3) == 0);
			phase_end = items_sent + $urandom_range(30, 70);
			while (items_sent < phase_end)
				send_string(board.quoted, $urandom_range(0, 4) != 0);
			phase_idx++;
		end

		// Drain and settle
		drop_input();
		while (board.expected_decodes.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (board.mismatches == 0 && board.expected_decodes.size() == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

endmodule
